// ===== hw/rtl/order_statistic_table_macros.svh =====
// Assertion helpers for the RTL of the order statistic table.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ORDER_STATISTIC_TABLE_MACROS_SVH
`define ORDER_STATISTIC_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ost_pkg.sv =====
`timescale 1ns / 1ps

package ost_pkg;

  // Field widths of the command and result words.
  localparam int FUNC_W   = 3;
  localparam int TIME_W   = 16;
  localparam int QUAL_W   = 16;
  localparam int RANK_W   = 7;
  localparam int STATUS_W = 2;

  // Command codes carried in the input word's tuser.
  typedef enum logic [FUNC_W-1:0] {
    FN_ADD      = 3'd0,
    FN_RM_TIME  = 3'd1,
    FN_RM_QUAL  = 3'd2,
    FN_SEL      = 3'd3,
    FN_RANGE    = 3'd4
  } ost_func_t;

  // Result status codes carried in the output word's tuser.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_DUP       = 2'd3
  } ost_status_t;

endpackage

// ===== hw/rtl/order_statistic_table.sv =====
`timescale 1ns / 1ps

// Order statistic table. Holds up to CAPACITY entries of (time, quality), kept
// sorted in one memory by quality and then time, with a fill count giving the
// number held; no two entries share a time. Each input word is one command:
// add, remove by time, remove all of one quality, select by rank, or select by
// rank within an inclusive time range, and each gives one output word with
// the selected time, a status and whether the special quality is held. The
// memory has one read port and each of these commands walks the held entries
// through it one per cycle; an add also shifts the entries that rank behind
// the new one up by one slot, one per cycle, then places the new entry. An
// unknown command code skips the walk. Writing special_quality while idle
// starts a walk that recomputes the presence flag, and s_tready stays low
// meanwhile. s_tready is low while a command is at work; a finished result
// waits in the output register without blocking the next command.
module order_statistic_table
  import ost_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  // Command word.
  input  logic                s_tvalid,
  output logic                s_tready,
  // tdata from bit 0: item_time[15:0], item_quality[15:0], rank[6:0],
  // time_a[15:0], time_b[15:0], one zero pad bit.
  input  logic [71:0]         s_tdata,
  // tuser from bit 0: func[2:0].
  input  logic [FUNC_W-1:0]   s_tuser,
  // Result word.
  output logic                m_tvalid,
  input  logic                m_tready,
  // tdata from bit 0: result_time[15:0], special_present, seven zero pad bits.
  output logic [23:0]         m_tdata,
  // tuser from bit 0: status[1:0].
  output logic [STATUS_W-1:0] m_tuser,
  // Special quality register.
  input  logic                cfg_we,
  input  logic [QUAL_W-1:0]   cfg_wdata
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_SELECT,
    OP_FLAG
  } op_t;

  // Entry memory, sorted, valid below count.
  logic [TIME_W-1:0] mem_time [CAPACITY];
  logic [QUAL_W-1:0] mem_qual [CAPACITY];

  state_t            state, state_next;
  op_t               op, op_next;
  logic              rm_by_time, rm_by_time_next;
  logic [TIME_W-1:0] key_time, key_time_next;
  logic [QUAL_W-1:0] key_qual, key_qual_next;
  logic [RANK_W-1:0] key_rank, key_rank_next;
  logic [TIME_W-1:0] lo, lo_next;
  logic [TIME_W-1:0] hi, hi_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     ptr, ptr_next;
  logic [CW-1:0]     acc, acc_next;
  logic              rd_vld, rd_vld_next;
  logic [AW-1:0]     rd_idx, rd_idx_next;
  logic              hit, hit_next;
  logic              flag_acc, flag_acc_next;
  logic [TIME_W-1:0] res_time, res_time_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [QUAL_W-1:0] special_quality;
  logic              special_flag, special_flag_next;
  logic              out_valid, out_valid_next;
  logic [TIME_W-1:0] out_time;
  logic [STATUS_W-1:0] out_status;
  logic              out_flag;
  logic              out_load;

  // Memory port signals.
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [TIME_W-1:0] rd_time;
  logic [QUAL_W-1:0] rd_qual;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [TIME_W-1:0] mem_wtime;
  logic [QUAL_W-1:0] mem_wqual;

  // Decoded command fields.
  logic [TIME_W-1:0] in_time, in_ta, in_tb;
  logic [QUAL_W-1:0] in_qual;
  logic [RANK_W-1:0] in_rank;
  logic              accept;

  // Per-entry tests on the word coming back from memory.
  logic              rd_match;
  logic              rd_in_range;
  logic              rd_ahead;
  logic [CW-1:0]     acc_inc;
  logic [CW-1:0]     ptr_dec;

  assign in_time = s_tdata[15:0];
  assign in_qual = s_tdata[31:16];
  assign in_rank = s_tdata[38:32];
  assign in_ta   = s_tdata[54:39];
  assign in_tb   = s_tdata[70:55];

  assign s_tready = (state == S_IDLE) && !cfg_we;
  assign accept   = s_tvalid && s_tready;

  assign rd_match    = rm_by_time ? (rd_time == key_time) : (rd_qual == key_qual);
  assign rd_in_range = (rd_time >= lo) && (rd_time <= hi);
  assign rd_ahead    = {rd_qual, rd_time} < {key_qual, key_time};
  assign acc_inc     = acc + CW'(1);
  assign ptr_dec     = ptr - CW'(1);

  // Entry memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_time[mem_waddr] <= mem_wtime;
      mem_qual[mem_waddr] <= mem_wqual;
    end
    if (mem_re) begin
      rd_time <= mem_time[mem_raddr];
      rd_qual <= mem_qual[mem_raddr];
    end
  end

  // Sequencer.
  always_comb begin
    state_next        = state;
    op_next           = op;
    rm_by_time_next   = rm_by_time;
    key_time_next     = key_time;
    key_qual_next     = key_qual;
    key_rank_next     = key_rank;
    lo_next           = lo;
    hi_next           = hi;
    count_next        = count;
    ptr_next          = ptr;
    acc_next          = acc;
    rd_vld_next       = 1'b0;
    rd_idx_next       = rd_idx;
    hit_next          = hit;
    flag_acc_next     = flag_acc;
    res_time_next     = res_time;
    res_status_next   = res_status;
    special_flag_next = special_flag;
    out_load          = 1'b0;
    mem_re            = 1'b0;
    mem_raddr         = ptr[AW-1:0];
    mem_we            = 1'b0;
    mem_waddr         = rd_idx;
    mem_wtime         = rd_time;
    mem_wqual         = rd_qual;

    unique case (state)
      S_IDLE: begin
        ptr_next      = '0;
        acc_next      = '0;
        hit_next      = 1'b0;
        flag_acc_next = 1'b0;
        if (cfg_we) begin
          // Recompute the presence flag under the new special quality.
          op_next    = OP_FLAG;
          state_next = S_SCAN;
        end else if (accept) begin
          key_time_next   = in_time;
          key_qual_next   = in_qual;
          key_rank_next   = in_rank;
          res_time_next   = '0;
          res_status_next = ST_NOT_FOUND;
          lo_next         = '0;
          hi_next         = '1;
          rm_by_time_next = 1'b0;
          state_next      = S_SCAN;
          unique case (s_tuser)
            FN_ADD: begin
              op_next = OP_ADD;
            end
            FN_RM_TIME: begin
              op_next         = OP_REMOVE;
              rm_by_time_next = 1'b1;
            end
            FN_RM_QUAL: begin
              op_next = OP_REMOVE;
            end
            FN_SEL: begin
              op_next = OP_SELECT;
            end
            FN_RANGE: begin
              op_next = OP_SELECT;
              lo_next = (in_ta < in_tb) ? in_ta : in_tb;
              hi_next = (in_ta < in_tb) ? in_tb : in_ta;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one read a cycle over the held entries.
        if (ptr != count) begin
          mem_re      = 1'b1;
          ptr_next    = ptr + CW'(1);
          rd_vld_next = 1'b1;
          rd_idx_next = ptr[AW-1:0];
        end
        // Act on the entry that came back.
        if (rd_vld) begin
          unique case (op)
            OP_ADD: begin
              if (rd_time == key_time) begin
                hit_next = 1'b1;
              end
              if (rd_ahead) begin
                acc_next = acc_inc;
              end
            end
            OP_REMOVE: begin
              if (rd_match) begin
                acc_next = acc_inc;
              end else begin
                // Survivors move down over the gap left by removed entries.
                mem_we    = 1'b1;
                mem_waddr = rd_idx - acc[AW-1:0];
                if (rd_qual == special_quality) begin
                  flag_acc_next = 1'b1;
                end
              end
            end
            OP_SELECT: begin
              if (rd_in_range) begin
                acc_next = acc_inc;
                if (!hit && CMPW'(acc_inc) == CMPW'(key_rank)) begin
                  hit_next      = 1'b1;
                  res_time_next = rd_time;
                end
              end
            end
            OP_FLAG: begin
              if (rd_qual == special_quality) begin
                flag_acc_next = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        // Walk finished.
        if (!rd_vld && ptr == count) begin
          unique case (op)
            OP_ADD: begin
              if (hit) begin
                res_status_next = ST_DUP;
                state_next      = S_DONE;
              end else if (count == CW'(CAPACITY)) begin
                res_status_next = ST_FULL;
                state_next      = S_DONE;
              end else begin
                state_next = S_SHIFT;
              end
            end
            OP_REMOVE: begin
              count_next        = count - acc;
              special_flag_next = flag_acc;
              res_status_next   = (acc != '0) ? ST_OK : ST_NOT_FOUND;
              state_next        = S_DONE;
            end
            OP_SELECT: begin
              res_status_next = hit ? ST_OK : ST_NOT_FOUND;
              state_next      = S_DONE;
            end
            OP_FLAG: begin
              special_flag_next = flag_acc;
              state_next        = S_IDLE;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // Move entries from the top down to the insert point up one slot.
        if (ptr != acc) begin
          mem_re      = 1'b1;
          mem_raddr   = ptr_dec[AW-1:0];
          ptr_next    = ptr_dec;
          rd_vld_next = 1'b1;
          rd_idx_next = ptr_dec[AW-1:0];
        end
        if (rd_vld) begin
          mem_we    = 1'b1;
          mem_waddr = rd_idx + AW'(1);
        end
        // Slot is open: place the new entry.
        if (!rd_vld && ptr == acc) begin
          mem_we          = 1'b1;
          mem_waddr       = acc[AW-1:0];
          mem_wtime       = key_time;
          mem_wqual       = key_qual;
          count_next      = count + CW'(1);
          res_status_next = ST_OK;
          if (key_qual == special_quality) begin
            special_flag_next = 1'b1;
          end
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output register handshake.
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end
    if (out_load) begin
      out_valid_next = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      count           <= '0;
      rd_vld          <= 1'b0;
      special_flag    <= 1'b0;
      special_quality <= '0;
      out_valid       <= 1'b0;
      op              <= OP_FLAG;
    end else begin
      state        <= state_next;
      count        <= count_next;
      rd_vld       <= rd_vld_next;
      special_flag <= special_flag_next;
      out_valid    <= out_valid_next;
      op           <= op_next;
      if (cfg_we) begin
        special_quality <= cfg_wdata;
      end
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk) begin
    rm_by_time <= rm_by_time_next;
    key_time   <= key_time_next;
    key_qual   <= key_qual_next;
    key_rank   <= key_rank_next;
    lo         <= lo_next;
    hi         <= hi_next;
    ptr        <= ptr_next;
    acc        <= acc_next;
    rd_idx     <= rd_idx_next;
    hit        <= hit_next;
    flag_acc   <= flag_acc_next;
    res_time   <= res_time_next;
    res_status <= res_status_next;
    if (out_load) begin
      out_time   <= res_time;
      out_status <= res_status;
      out_flag   <= special_flag;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_flag, out_time};
  assign m_tuser  = out_status;

  // Checks on the sequencer.
`include "order_statistic_table_macros.svh"

  `OST_ASSERT_SAME(a_count_bound, 1'b1, count <= CW'(CAPACITY), "fill count above capacity")
  `OST_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready, "ready right after a command")
  `OST_ASSERT_SAME(a_no_shift_when_full, state == S_SHIFT, count != CW'(CAPACITY),
                   "insert shift on a full table")
  `OST_ASSERT_SAME(a_zero_time_on_error, m_tvalid && m_tuser != ST_OK, m_tdata[15:0] == '0,
                   "result time not zero on a failed command")

endmodule
